FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros: same-cycle and next-cycle implication,
// both clocked on the rising edge and held off while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/nscs_pkg.sv
// ---------------------------------------------------------------------------
// nscs_pkg
// Types and fixed constants of the nested scissor clip stack.
// ---------------------------------------------------------------------------
`default_nettype none

package nscs_pkg;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;
  localparam int DEPTH_W    = 5;
  localparam int TH_W       = 15;
  localparam int ALU_W      = 18;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DRAW  = 1'b1;

  // One clip box as held in the stack.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
  } box_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_M9,
    ST_WR,
    ST_F0,
    ST_F1,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: src/nscs_ram.sv
// ---------------------------------------------------------------------------
// nscs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module nscs_ram #(
  parameter int WIDTH = 62,
  parameter int DEPTH = 17
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: src/nested_scissor_clip_stack_core.sv
// ---------------------------------------------------------------------------
// nested_scissor_clip_stack_core
// Stack of nested axis-aligned scissor boxes, one result beat per item beat.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (in_*): one beat per item. in_tuser carries the kind (start
//   of list or draw item); in_tdata carries the box, clip depth, clipping
//   flag and target height. A start beat resets the stack to the root box.
//   A draw beat cuts the stack back to its clip depth, replaces a sibling
//   clip at the same depth and, when clipping, pushes its box intersected
//   with the parent box. A push onto a full stack is dropped and flagged.
//   Output stream (out_*): exactly one beat per input beat, in order, with
//   the enable flag, the top box (y flipped against the target height) and
//   the overflow flag.
// Timing: all arithmetic goes through one 18-bit add/subtract unit stepped
//   by the state machine, and the stack lives in a RAM with registered read.
//   A start flips y; a draw on an empty stack goes straight to the result;
//   other draws read the top, intersect and push if clipping and not full,
//   then flip y. in_tready is low while an item is in progress.
// Stall: the result sits in an output register; the next input beat is
//   taken while it waits, and the block holds in its last step only when a
//   new result is ready and the old one has not been taken.
// Reset: synchronous, active low; empties the stack and drops any pending
//   result. Stack RAM contents are not cleared and need not be.
// ---------------------------------------------------------------------------
`default_nettype none

module nested_scissor_clip_stack_core #(
  parameter int STACK_DEPTH = 17
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // in_tdata, low bit up: box_x[15:0], box_y[31:16], box_width[46:32],
  // box_height[61:47], clip_depth[66:62], is_clipping[67],
  // target_height[82:68], zero pad[87:83]
  input  wire logic [nscs_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: kind[0]
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // out_tdata, low bit up: scissor_enable[0], scissor_x[16:1],
  // scissor_y[33:17], scissor_width[48:34], scissor_height[63:49],
  // overflow[64], zero pad[71:65]
  output logic      [nscs_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int KW = (CW > nscs_pkg::DEPTH_W) ? CW : nscs_pkg::DEPTH_W;
  localparam int BW = $bits(nscs_pkg::box_t);

  // Decode of the input beat
  logic                          in_kind;
  nscs_pkg::box_t                in_box;
  logic [nscs_pkg::DEPTH_W-1:0]  in_depth;
  logic                          in_clip;
  logic [nscs_pkg::TH_W-1:0]     in_th;

  assign in_kind    = in_tuser;
  assign in_box.x   = in_tdata[15:0];
  assign in_box.y   = in_tdata[31:16];
  assign in_box.w   = in_tdata[46:32];
  assign in_box.h   = in_tdata[61:47];
  assign in_depth   = in_tdata[66:62];
  assign in_clip    = in_tdata[67];
  assign in_th      = in_tdata[82:68];

  // Registers
  nscs_pkg::state_t              state_r, state_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [nscs_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  nscs_pkg::box_t                a_r, a_nxt;
  nscs_pkg::box_t                b_r, b_nxt;
  logic [nscs_pkg::TH_W-1:0]     th_r, th_nxt;
  logic [AW-1:0]                 addr_r, addr_nxt;
  logic                          meet_r, meet_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          en_r, en_nxt;
  logic signed [15:0]            rx_r, rx_nxt;
  logic signed [15:0]            ry_r, ry_nxt;
  logic [14:0]                   rw_r, rw_nxt;
  logic [14:0]                   rh_r, rh_nxt;
  logic signed [nscs_pkg::ALU_W-1:0] ea_r, ea_nxt;
  logic signed [nscs_pkg::ALU_W-1:0] eb_r, eb_nxt;
  logic signed [nscs_pkg::ALU_W-1:0] em_r, em_nxt;
  logic signed [16:0]            fy_r, fy_nxt;

  // Stack cut-back decision on the accepted beat
  logic [CW-1:0] child, cut1, cut2, new_count;
  logic          full;

  always_comb begin
    child = count_r - CW'(1);
    cut1  = (KW'(in_depth) < KW'(child)) ? CW'(in_depth) : child;
    cut2  = (in_clip && (cut1 != '0) && (KW'(cut1) == KW'(in_depth)))
          ? cut1 - CW'(1) : cut1;
    new_count = cut2 + CW'(1);
    full      = (new_count >= CW'(STACK_DEPTH));
  end

  // Shared add/subtract unit
  logic signed [nscs_pkg::ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic                              alu_sub, alu_neg;

  assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  assign alu_neg = alu_sum[nscs_pkg::ALU_W-1];

  // Stack RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [BW-1:0] ram_wdata, ram_rdata;
  nscs_pkg::box_t rd_box, r_box;

  assign rd_box   = ram_rdata;
  assign r_box.x  = rx_r;
  assign r_box.y  = ry_r;
  assign r_box.w  = rw_r;
  assign r_box.h  = rh_r;

  nscs_ram #(
    .WIDTH (BW),
    .DEPTH (STACK_DEPTH)
  ) u_nscs_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  logic in_acc;
  assign in_tready  = (state_r == nscs_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    th_nxt         = th_r;
    addr_nxt       = addr_r;
    meet_nxt       = meet_r;
    ovf_nxt        = ovf_r;
    en_nxt         = en_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    rw_nxt         = rw_r;
    rh_nxt         = rh_r;
    ea_nxt         = ea_r;
    eb_nxt         = eb_r;
    em_nxt         = em_r;
    fy_nxt         = fy_r;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = addr_r + AW'(1);
    ram_wdata      = r_box;

    // Drop the result beat once taken
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      nscs_pkg::ST_IDLE: begin
        if (in_acc) begin
          b_nxt  = in_box;
          th_nxt = in_th;
          ovf_nxt = 1'b0;
          meet_nxt = 1'b0;
          if (in_kind == nscs_pkg::KIND_START) begin
            // Root box goes to the bottom slot and is the top at once
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_box;
            count_nxt = CW'(1);
            a_nxt     = in_box;
            en_nxt    = 1'b1;
            state_nxt = nscs_pkg::ST_F0;
          end else if (count_r == '0) begin
            en_nxt    = 1'b0;
            state_nxt = nscs_pkg::ST_DONE;
          end else begin
            en_nxt   = 1'b1;
            addr_nxt = AW'(cut2);
            if (in_clip && full) begin
              ovf_nxt   = 1'b1;
              count_nxt = new_count;
            end else if (in_clip) begin
              meet_nxt  = 1'b1;
              count_nxt = new_count + CW'(1);
            end else begin
              count_nxt = new_count;
            end
            state_nxt = nscs_pkg::ST_RD;
          end
        end
      end
      nscs_pkg::ST_RD: begin
        state_nxt = nscs_pkg::ST_LD;
      end
      nscs_pkg::ST_LD: begin
        a_nxt     = rd_box;
        state_nxt = meet_r ? nscs_pkg::ST_M0 : nscs_pkg::ST_F0;
      end
      // Intersection: max of left and top edges, then x axis: min of right edges
      nscs_pkg::ST_M0: begin
        alu_a = nscs_pkg::ALU_W'(a_r.x);
        alu_b = nscs_pkg::ALU_W'(b_r.x);
        alu_sub = 1'b1;
        rx_nxt = alu_neg ? b_r.x : a_r.x;
        state_nxt = nscs_pkg::ST_M1;
      end
      nscs_pkg::ST_M1: begin
        alu_a = nscs_pkg::ALU_W'(a_r.y);
        alu_b = nscs_pkg::ALU_W'(b_r.y);
        alu_sub = 1'b1;
        ry_nxt = alu_neg ? b_r.y : a_r.y;
        state_nxt = nscs_pkg::ST_M2;
      end
      nscs_pkg::ST_M2: begin
        alu_a = nscs_pkg::ALU_W'(a_r.x);
        alu_b = $signed({3'b000, a_r.w});
        ea_nxt = alu_sum;
        state_nxt = nscs_pkg::ST_M3;
      end
      nscs_pkg::ST_M3: begin
        alu_a = nscs_pkg::ALU_W'(b_r.x);
        alu_b = $signed({3'b000, b_r.w});
        eb_nxt = alu_sum;
        state_nxt = nscs_pkg::ST_M4;
      end
      nscs_pkg::ST_M4: begin
        alu_a = ea_r;
        alu_b = eb_r;
        alu_sub = 1'b1;
        em_nxt = alu_neg ? ea_r : eb_r;
        state_nxt = nscs_pkg::ST_M5;
      end
      nscs_pkg::ST_M5: begin
        // Clamp at zero; a positive span never exceeds either width
        alu_a = em_r;
        alu_b = nscs_pkg::ALU_W'(rx_r);
        alu_sub = 1'b1;
        rw_nxt = alu_neg ? '0 : alu_sum[14:0];
        state_nxt = nscs_pkg::ST_M6;
      end
      // Intersection, y axis
      nscs_pkg::ST_M6: begin
        alu_a = nscs_pkg::ALU_W'(a_r.y);
        alu_b = $signed({3'b000, a_r.h});
        ea_nxt = alu_sum;
        state_nxt = nscs_pkg::ST_M7;
      end
      nscs_pkg::ST_M7: begin
        alu_a = nscs_pkg::ALU_W'(b_r.y);
        alu_b = $signed({3'b000, b_r.h});
        eb_nxt = alu_sum;
        state_nxt = nscs_pkg::ST_M8;
      end
      nscs_pkg::ST_M8: begin
        alu_a = ea_r;
        alu_b = eb_r;
        alu_sub = 1'b1;
        em_nxt = alu_neg ? ea_r : eb_r;
        state_nxt = nscs_pkg::ST_M9;
      end
      nscs_pkg::ST_M9: begin
        alu_a = em_r;
        alu_b = nscs_pkg::ALU_W'(ry_r);
        alu_sub = 1'b1;
        rh_nxt = alu_neg ? '0 : alu_sum[14:0];
        state_nxt = nscs_pkg::ST_WR;
      end
      nscs_pkg::ST_WR: begin
        // Push the intersection just above the parent
        ram_we    = 1'b1;
        a_nxt     = r_box;
        state_nxt = nscs_pkg::ST_F0;
      end
      // Flip y: target height minus bottom edge of the top box
      nscs_pkg::ST_F0: begin
        alu_a = nscs_pkg::ALU_W'(a_r.y);
        alu_b = $signed({3'b000, a_r.h});
        ea_nxt = alu_sum;
        state_nxt = nscs_pkg::ST_F1;
      end
      nscs_pkg::ST_F1: begin
        alu_a = $signed({3'b000, th_r});
        alu_b = ea_r;
        alu_sub = 1'b1;
        fy_nxt = alu_sum[16:0];
        state_nxt = nscs_pkg::ST_DONE;
      end
      nscs_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          if (en_r) begin
            out_tdata_nxt = {7'b0, ovf_r, a_r.h, a_r.w, fy_r, a_r.x, 1'b1};
          end else begin
            out_tdata_nxt = {7'b0, ovf_r, 64'b0};
          end
          state_nxt = nscs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nscs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= nscs_pkg::ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    th_r        <= th_nxt;
    addr_r      <= addr_nxt;
    meet_r      <= meet_nxt;
    ovf_r       <= ovf_nxt;
    en_r        <= en_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    rw_r        <= rw_nxt;
    rh_r        <= rh_nxt;
    ea_r        <= ea_nxt;
    eb_r        <= eb_nxt;
    em_r        <= em_nxt;
    fy_r        <= fy_nxt;
  end

endmodule

`default_nettype wire

FILE: src/nscs_checker.sv
// ---------------------------------------------------------------------------
// nscs_checker
// Port-level checks of the clip stack core, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module nscs_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [nscs_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic in_beat;
  assign in_beat = in_tvalid && in_tready;

  // A stalled result beat holds its payload
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // The block is busy in the cycle after taking a beat
  `ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_beat, !in_tready)

  // A disabled scissor carries an all-zero box and no overflow
  `ASSERT_IMPLIES(a_disabled_zero, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[64:1] == 64'd0)

  // Overflow only comes with an enabled scissor
  `ASSERT_IMPLIES(a_ovf_enabled, clk, rst_n, out_tvalid && out_tdata[64], out_tdata[0])

endmodule

bind nested_scissor_clip_stack_core nscs_checker u_nscs_checker (.*);

`default_nettype wire

FILE: dv/scissor_stack_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scissor_stack_checker
// Watches both streams of the clip stack core, keeps its own copy of the
// box stack, predicts each result beat and compares it field by field.
// ---------------------------------------------------------------------------
module scissor_stack_checker import nscs_pkg::*; #(
  parameter int STACK_DEPTH = 17
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,
  output int                         fail_count,
  output int                         outstanding,
  output int                         checked_count,
  output int                         overflow_count,
  output int                         deepest
);

  typedef struct {
    logic               en;
    logic signed [15:0] x;
    logic signed [16:0] y;
    logic [14:0]        w;
    logic [14:0]        h;
    logic               ovf;
  } scissor_t;

  box_t     clip_stack [STACK_DEPTH];
  int       stack_fill;
  scissor_t scissor_q [$];

  scissor_t got;
  scissor_t want;
  box_t     item;

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, int got_v, int want_v);
    if (got_v != want_v) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got_v, want_v));
    end
  endtask

  // Overlap of two boxes; an empty overlap keeps the larger start edges.
  function automatic box_t overlap_box(box_t a, box_t b);
    int   lft, top, rgt, bot;
    box_t r;
    lft = (int'(a.x) > int'(b.x)) ? int'(a.x) : int'(b.x);
    top = (int'(a.y) > int'(b.y)) ? int'(a.y) : int'(b.y);
    rgt = int'(a.x) + int'(a.w);
    if (int'(b.x) + int'(b.w) < rgt) rgt = int'(b.x) + int'(b.w);
    bot = int'(a.y) + int'(a.h);
    if (int'(b.y) + int'(b.h) < bot) bot = int'(b.y) + int'(b.h);
    r.x = 16'(lft);
    r.y = 16'(top);
    r.w = (rgt > lft) ? 15'(rgt - lft) : '0;
    r.h = (bot > top) ? 15'(bot - top) : '0;
    return r;
  endfunction

  // Apply one item to the stack and return the scissor it yields.
  function automatic scissor_t step_clip_stack(logic kind, box_t box, logic [4:0] depth,
                                               logic clipping, logic [14:0] th);
    int       child;
    int       fy;
    box_t     top_box;
    scissor_t res;
    res = '{default: '0};
    if (kind == KIND_START) begin
      clip_stack[0] = box;
      stack_fill    = 1;
    end else if (stack_fill > 0) begin
      child = stack_fill - 1;
      // cut back to the item's clip depth
      while (child > 0 && int'(depth) < child) begin
        stack_fill--;
        child--;
      end
      // a clipping sibling at the same depth gives way
      if (clipping && child > 0 && child == int'(depth)) begin
        stack_fill--;
        child--;
      end
      if (clipping) begin
        if (stack_fill >= STACK_DEPTH) begin
          res.ovf = 1'b1;
        end else begin
          clip_stack[stack_fill] = overlap_box(clip_stack[stack_fill-1], box);
          stack_fill++;
        end
      end
    end
    if (stack_fill > 0) begin
      top_box = clip_stack[stack_fill-1];
      fy      = int'(th) - (int'(top_box.y) + int'(top_box.h));
      res.en  = 1'b1;
      res.x   = top_box.x;
      res.y   = 17'(fy);
      res.w   = top_box.w;
      res.h   = top_box.h;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      stack_fill = 0;
      scissor_q.delete();
    end else begin
      // retire a result beat first; it can never belong to this edge's input
      if (out_tvalid && out_tready) begin
        got.en  = out_tdata[0];
        got.x   = out_tdata[16:1];
        got.y   = out_tdata[33:17];
        got.w   = out_tdata[48:34];
        got.h   = out_tdata[63:49];
        got.ovf = out_tdata[64];
        if (scissor_q.size() == 0) begin
          report_mismatch("result beat with no item waiting");
        end else begin
          want = scissor_q.pop_front();
          check_field("scissor_enable", int'(got.en), int'(want.en));
          check_field("scissor_x", int'(got.x), int'(want.x));
          check_field("scissor_y", int'(got.y), int'(want.y));
          check_field("scissor_width", int'(got.w), int'(want.w));
          check_field("scissor_height", int'(got.h), int'(want.h));
          check_field("overflow", int'(got.ovf), int'(want.ovf));
          checked_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        item.x = in_tdata[15:0];
        item.y = in_tdata[31:16];
        item.w = in_tdata[46:32];
        item.h = in_tdata[61:47];
        want   = step_clip_stack(in_tuser, item, in_tdata[66:62], in_tdata[67],
                                 in_tdata[82:68]);
        scissor_q = {scissor_q, want};
        if (want.ovf) overflow_count++;
        if (stack_fill > deepest) deepest = stack_fill;
      end
      outstanding = scissor_q.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the nested scissor clip stack core: directed
// corner items, then random display lists of nested clip boxes, with random
// idle cycles on both streams. Checking lives in scissor_stack_checker.
// ---------------------------------------------------------------------------
module tb;
  import nscs_pkg::*;

  localparam int STACK_DEPTH  = 17;
  localparam int RANDOM_ITEMS = 600;
  // The slowest item plus random idle on each side bounds the time per beat;
  // allow several times that for the whole run.
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int outstanding;
  int checked_count;
  int overflow_count;
  int deepest;

  int   cycle_count = 0;
  int   start_count = 0;
  int   beat_count  = 0;
  // while set, neither side inserts idle cycles
  logic steady      = 1'b0;

  nested_scissor_clip_stack_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  scissor_stack_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .checked_count (checked_count),
    .overflow_count(overflow_count),
    .deepest       (deepest)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop: anything still running here is hung.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: per beat, optionally keep tready low for a random stall once the
  // result shows up, so the core has to park it in its output register.
  initial begin
    int stall;
    out_tready = 1'b0;
    @(negedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        while (!out_tvalid) @(negedge clk);
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      @(negedge clk);
    end
  end

  // Drive one item beat: a random idle gap, then hold until the core takes it.
  // Called at a falling edge and returns at one.
  task automatic send_beat(logic kind, box_t box, logic [4:0] depth, logic clipping,
                           logic [14:0] th);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'b0, th, clipping, depth, box.h, box.w, box.y, box.x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    beat_count++;
    if (kind == KIND_START) start_count++;
  endtask

  // Mostly small boxes near the origin so that nesting actually clips;
  // now and then anything the fields hold.
  function automatic box_t pick_box();
    box_t b;
    if ($urandom_range(0, 7) == 0) begin
      b.x = 16'($urandom);
      b.y = 16'($urandom);
      b.w = 15'($urandom);
      b.h = 15'($urandom);
    end else begin
      b.x = 16'(int'($urandom_range(0, 2400)) - 1200);
      b.y = 16'(int'($urandom_range(0, 2400)) - 1200);
      b.w = 15'($urandom_range(0, 1600));
      b.h = 15'($urandom_range(0, 1600));
    end
    return b;
  endfunction

  function automatic logic [14:0] pick_th();
    return ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 3000));
  endfunction

  task automatic run_directed();
    box_t b;
    // draw with every field all ones before any list start: empty stack
    send_beat(KIND_DRAW, '{16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF}, 5'd31, 1'b1, 15'h7FFF);
    // root at the most negative corner, full size
    send_beat(KIND_START, '{16'h8000, 16'h8000, 15'h7FFF, 15'h7FFF}, 5'd0, 1'b0, 15'h7FFF);
    // non-clipping item over the bare root
    send_beat(KIND_DRAW, '{16'h0000, 16'h0000, 15'h0000, 15'h0000}, 5'd0, 1'b0, 15'h0000);
    // clip fully outside the root: zero-size overlap
    send_beat(KIND_DRAW, '{16'h7FFF, 16'h7FFF, 15'h7FFF, 15'h7FFF}, 5'd1, 1'b1, 15'h7FFF);
    // same depth again: replaces the sibling
    send_beat(KIND_DRAW, '{-16'sd100, -16'sd200, 15'd50, 15'd60}, 5'd1, 1'b1, 15'd1000);
    send_beat(KIND_DRAW, '{-16'sd90, -16'sd190, 15'd100, 15'd10}, 5'd2, 1'b1, 15'd500);
    // drop back to the root
    send_beat(KIND_DRAW, '{16'h0000, 16'h0000, 15'h0000, 15'h0000}, 5'd0, 1'b0, 15'h0000);
    // new list, then fill the stack and push once more
    send_beat(KIND_START, '{16'h0000, 16'h0000, 15'd4096, 15'd4096}, 5'd0, 1'b0, 15'd4096);
    for (int d = 1; d <= 16; d++) begin
      b.x = 16'(d * 8);
      b.y = 16'(d * 4);
      b.w = 15'(4000 - d * 16);
      b.h = 15'(4000 - d * 8);
      send_beat(KIND_DRAW, b, 5'(d), 1'b1, 15'd4096);
    end
    send_beat(KIND_DRAW, '{16'h0010, 16'h0010, 15'd20, 15'd20}, 5'd31, 1'b1, 15'd4096);
  endtask

  // Random display lists: a start beat, then draw items whose clip depth
  // follows a legal nesting walk. Some lists dive straight down to overrun
  // the stack; a slice of beats is plain noise.
  task automatic run_random_lists();
    int   r;
    int   lvl;
    int   nest_level;
    logic deep_list;
    logic clipping;
    nest_level = 0;
    deep_list  = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      // hold the sender off once until every result is back
      if (n == RANDOM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
      r = $urandom_range(0, 99);
      if (n == 0 || r < 5) begin
        send_beat(KIND_START, pick_box(), 5'($urandom), 1'($urandom), pick_th());
        nest_level = 0;
        deep_list  = ($urandom_range(0, 3) == 0);
      end else if (r < 13) begin
        send_beat(KIND_DRAW, pick_box(), 5'($urandom), 1'($urandom), pick_th());
      end else begin
        clipping = deep_list ? ($urandom_range(0, 9) != 0) : 1'($urandom);
        if (clipping) begin
          lvl = deep_list ? nest_level + 1 : $urandom_range(1, nest_level + 1);
        end else begin
          lvl = $urandom_range(0, nest_level);
        end
        if (lvl > 31) lvl = 31;
        nest_level = lvl;
        send_beat(KIND_DRAW, pick_box(), 5'(lvl), clipping, pick_th());
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = KIND_START;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    run_random_lists();

    // drain, then give the core a little longer than its slowest item
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);

    $display("Sent %0d item beats in %0d display lists; %0d results checked.",
             beat_count, start_count, checked_count);
    $display("Stack reached %0d of %0d entries; %0d pushes dropped on a full stack.",
             deepest, STACK_DEPTH, overflow_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
